FILE: sv/dlp_pkg.sv
// Shared constants, types and the prefix table for the distance line parser.
package dlp_pkg;

  localparam int unsigned LINE_CAPACITY_DEF = 64;
  localparam int unsigned PREFIX_LEN        = 9;
  localparam int unsigned ACC_W             = 14;
  localparam logic [31:0] TIMEOUT_RST       = 32'd100;
  localparam logic [ACC_W-1:0] VALUE_MAX    = 14'd9999;
  localparam logic [ACC_W-1:0] ACC_SAT      = 14'd10000;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic             prefix_ok;
    phase_t           phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
  } parse_st_t;

  localparam parse_st_t PARSE_CLR = '{prefix_ok: 1'b1, phase: PH_SKIP, neg: 1'b0,
                                      acc: '0};

  // Expected character of "distance:" at each prefix position.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h64;  // d
      4'd1:    c = 8'h69;  // i
      4'd2:    c = 8'h73;  // s
      4'd3:    c = 8'h74;  // t
      4'd4:    c = 8'h61;  // a
      4'd5:    c = 8'h6E;  // n
      4'd6:    c = 8'h63;  // c
      4'd7:    c = 8'h65;  // e
      4'd8:    c = 8'h3A;  // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/dlp_char_parse.sv
// Parse step for one released character: prefix check, then atoi-style number.
module dlp_char_parse import dlp_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF,
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY)
) (
  input  logic             en,
  input  logic [7:0]       ch,
  input  logic [LEN_W-1:0] pos,
  input  parse_st_t        st_in,
  output parse_st_t        st_out
);

  logic             in_prefix;
  logic             is_blank;
  logic             is_sign;
  logic             is_digit;
  logic [ACC_W+2:0] acc_wide;

  assign in_prefix = pos < LEN_W'(PREFIX_LEN);
  assign is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  // acc * 10 + digit, with acc at most 10000 this fits in 17 bits.
  assign acc_wide  = {st_in.acc, 3'b000} + {2'b00, st_in.acc, 1'b0}
                   + {(ACC_W-1)'(0), ch[3:0]};

  always_comb begin
    st_out = st_in;
    if (en) begin
      if (in_prefix) begin
        if (ch != prefix_char(pos[3:0])) begin
          st_out.prefix_ok = 1'b0;
        end
      end else if ((st_in.phase == PH_SKIP) && is_blank) begin
        st_out = st_in;
      end else if ((st_in.phase == PH_SKIP) && is_sign) begin
        st_out.neg   = (ch == CH_MINUS);
        st_out.phase = PH_DIGITS;
      end else if ((st_in.phase == PH_SKIP) || (st_in.phase == PH_DIGITS)) begin
        if (is_digit) begin
          st_out.phase = PH_DIGITS;
          st_out.acc   = (acc_wide > (ACC_W+3)'(ACC_SAT)) ? ACC_SAT : acc_wide[ACC_W-1:0];
        end else begin
          st_out.phase = PH_DONE;
        end
      end
    end
  end

endmodule

FILE: sv/distance_line_parser.sv
// Top level of the distance line parser.
// Takes one received byte with its millisecond timestamp per request and returns one result
// per request: the held distance and flags telling whether this byte ended a line and whether
// that line carried a valid "distance:NNN" value (0 to 9999). Each byte is handled in a single
// pass of logic into an output register, so a request is accepted every cycle as long as the
// result side keeps taking results; out_valid is set in the cycle after acceptance.
// A gap longer than cfg timeout discards the partial line; a line also ends when
// LINE_CAPACITY-1 characters are stored. The newest stored character is parsed only when the
// next one arrives, so the CR before LF is never parsed.
module distance_line_parser import dlp_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_distance_out,
  output logic        out_line_done,
  output logic        out_updated,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);

  logic [31:0]      timeout_r;
  logic [31:0]      last_time_r;
  logic [7:0]       prev_byte_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       held_r, held_nxt;
  parse_st_t        pst_r, pst_nxt;
  logic [13:0]      dist_r, dist_nxt;
  logic             out_valid_r;
  logic [13:0]      out_dist_r;
  logic             out_done_r;
  logic             out_upd_r;

  logic             accept;
  logic             timed_out;
  logic [LEN_W-1:0] len_eff;
  logic [7:0]       held_eff;
  parse_st_t        pst_eff;
  parse_st_t        pst_parsed;
  logic             done_c;
  logic             upd_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  // Line state as seen after a possible timeout discard.
  assign timed_out = (in_now_ms - last_time_r) > timeout_r;
  assign len_eff   = timed_out ? '0 : len_r;
  assign held_eff  = timed_out ? 8'h00 : held_r;
  assign pst_eff   = timed_out ? PARSE_CLR : pst_r;

  assign done_c = ((prev_byte_r == CH_CR) && (in_rx_byte == CH_LF))
               || (len_eff >= LEN_W'(LINE_CAPACITY - 1));

  dlp_char_parse #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parse (
    .en     (len_eff != '0),
    .ch     (held_eff),
    .pos    (len_eff - LEN_W'(1)),
    .st_in  (pst_eff),
    .st_out (pst_parsed)
  );

  always_comb begin
    upd_c    = 1'b0;
    dist_nxt = dist_r;
    if (done_c) begin
      len_nxt  = '0;
      held_nxt = 8'h00;
      pst_nxt  = PARSE_CLR;
      // Need the prefix plus the dropped character at the end.
      if (pst_eff.prefix_ok && (len_eff >= LEN_W'(PREFIX_LEN + 1))) begin
        if (pst_eff.neg) begin
          if (pst_eff.acc == '0) begin
            dist_nxt = '0;
            upd_c    = 1'b1;
          end
        end else if (pst_eff.acc <= VALUE_MAX) begin
          dist_nxt = pst_eff.acc;
          upd_c    = 1'b1;
        end
      end
    end else begin
      len_nxt  = len_eff + LEN_W'(1);
      held_nxt = in_rx_byte;
      pst_nxt  = pst_parsed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      last_time_r <= '0;
      prev_byte_r <= '0;
      len_r       <= '0;
      held_r      <= '0;
      pst_r       <= PARSE_CLR;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (accept) begin
        last_time_r <= in_now_ms;
        prev_byte_r <= in_rx_byte;
        len_r       <= len_nxt;
        held_r      <= held_nxt;
        pst_r       <= pst_nxt;
        dist_r      <= dist_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_dist_r <= dist_nxt;
      out_done_r <= done_c;
      out_upd_r  <= upd_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance_out = out_dist_r;
  assign out_line_done    = out_done_r;
  assign out_updated      = out_upd_r;

  a_upd_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_updated || out_line_done))
    else $error("update reported without a line end");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    dist_r <= VALUE_MAX)
    else $error("held distance out of range");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_CAPACITY - 1))
    else $error("line length beyond capacity");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done_c) |=> (len_r == '0 && pst_r.prefix_ok))
    else $error("line state not cleared after line end");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the distance line parser: random and directed byte streams.
`timescale 1ns / 1ps

module testbench;
  import dlp_pkg::*;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } rx_item_t;

  typedef struct packed {
    logic [13:0] distance;
    logic        line_done;
    logic        updated;
  } line_result_t;

  localparam logic [71:0] PREFIX_TEXT = "distance:";
  localparam int unsigned PHASE_ITEMS = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic [31:0] in_now_ms = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] out_distance_out;
  logic        out_line_done;
  logic        out_updated;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;

  distance_line_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_distance_out (out_distance_out),
    .out_line_done    (out_line_done),
    .out_updated      (out_updated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  rx_item_t     rx_pending[$];
  line_result_t result_due[$];
  int unsigned  mismatches = 0;
  int unsigned  bytes_queued = 0;
  int unsigned  results_seen = 0;

  // Parser state as the predictor sees it.
  logic [31:0] p_timeout;
  logic [31:0] p_last_ms;
  logic [7:0]  p_prev_byte;
  logic [5:0]  p_len;
  logic [7:0]  p_held;
  logic        p_prefix_ok;
  phase_t      p_phase;
  logic        p_neg;
  logic [13:0] p_acc;
  logic [13:0] p_distance;

  // Stimulus timing.
  logic [31:0] cur_ms;
  logic [31:0] ph_timeout;
  int          in_gap = 0;
  int          out_gap = 0;
  logic        in_burst = 1'b0;
  logic        out_burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_line_state();
    p_len       = '0;
    p_held      = '0;
    p_prefix_ok = 1'b1;
    p_phase     = PH_SKIP;
    p_neg       = 1'b0;
    p_acc       = '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic line_result_t parse_rx_byte(input logic [7:0] b, input logic [31:0] now);
    line_result_t res;
    logic [7:0]   c;
    logic [5:0]   pos;
    int unsigned  acc_next;
    res.line_done = 1'b0;
    res.updated   = 1'b0;
    if (now - p_last_ms > p_timeout) clear_line_state();
    p_last_ms = now;
    if ((p_prev_byte == CH_CR && b == CH_LF) || p_len >= LINE_CAPACITY_DEF - 1) begin
      res.line_done = 1'b1;
      if (p_len >= 2 && p_prefix_ok && p_len - 1 >= PREFIX_LEN) begin
        if (p_neg) begin
          if (p_acc == '0) begin
            p_distance  = '0;
            res.updated = 1'b1;
          end
        end else if (p_acc <= VALUE_MAX) begin
          p_distance  = p_acc;
          res.updated = 1'b1;
        end
      end
      clear_line_state();
    end else begin
      // The held character is parsed only now that a newer one is stored.
      if (p_len >= 1) begin
        c   = p_held;
        pos = p_len - 6'd1;
        if (pos < PREFIX_LEN) begin
          if (c != PREFIX_TEXT[71 - 8*pos -: 8]) p_prefix_ok = 1'b0;
        end else begin
          if (p_phase == PH_SKIP) begin
            if (is_blank(c)) begin
              // still skipping leading whitespace
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              p_neg   = (c == CH_MINUS);
              p_phase = PH_DIGITS;
              c       = CH_SPACE;  // the sign itself is not a digit
            end else begin
              p_phase = PH_DIGITS;
            end
          end
          if (p_phase == PH_DIGITS && !(is_blank(c) && c == CH_SPACE && p_len - 1 == pos
              && (p_held == CH_PLUS || p_held == CH_MINUS))) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              acc_next = p_acc * 10 + (c - CH_ZERO);
              p_acc = (acc_next > ACC_SAT) ? ACC_SAT : acc_next[13:0];
            end else begin
              p_phase = PH_DONE;
            end
          end
        end
      end
      p_held = b;
      p_len  = p_len + 6'd1;
    end
    p_prev_byte  = b;
    res.distance = p_distance;
    return res;
  endfunction

  // Request side: presents queued bytes and predicts each accepted one.
  always @(posedge clk) begin : drive_requests
    rx_item_t nxt;
    logic     hold;
    hold = in_valid && !in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) result_due.push_back(parse_rx_byte(in_rx_byte, in_now_ms));
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          nxt = rx_pending.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= nxt.rx_byte;
          in_now_ms  <= nxt.now_ms;
          if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input int unsigned exp_v, input int unsigned act_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  // Result side: random stalls, each result checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    line_result_t exp_r;
    logic         rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got distance %0d done %0b upd %0b",
                   $time, out_distance_out, out_line_done, out_updated);
          mismatches++;
        end else begin
          exp_r = result_due.pop_front();
          if (out_distance_out !== exp_r.distance)
            report("distance_out", exp_r.distance, out_distance_out);
          if (out_line_done !== exp_r.line_done)
            report("line_done", exp_r.line_done, out_line_done);
          if (out_updated !== exp_r.updated)
            report("updated", exp_r.updated, out_updated);
        end
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        out_gap = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_gap > 0) begin
        out_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  task automatic push_at(input logic [7:0] b, input logic [31:0] t);
    rx_item_t it;
    it.rx_byte = b;
    it.now_ms  = t;
    cur_ms     = t;
    rx_pending.push_back(it);
    bytes_queued++;
  endtask

  // Mostly short gaps, with the odd gap right at or just past the timeout, or a wild jump.
  task automatic push_byte(input logic [7:0] b);
    int unsigned r;
    logic [31:0] d;
    r = $urandom_range(0, 999);
    if (r < 8)       d = $urandom();
    else if (r < 16) d = ph_timeout;
    else if (r < 24) d = ph_timeout + 32'd1;
    else             d = $urandom_range(0, (ph_timeout < 3) ? ph_timeout : 3);
    push_at(b, cur_ms + d);
  endtask

  task automatic push_prefix(input int unsigned count);
    for (int i = 0; i < count; i++) push_byte(PREFIX_TEXT[71 - 8*i -: 8]);
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  task automatic push_number(input int unsigned v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) digs.push_front(CH_ZERO);
    foreach (digs[i]) push_byte(digs[i]);
  endtask

  task automatic gen_line();
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    int unsigned bad;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      push_prefix(PREFIX_LEN);
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 2)) push_byte(blank_char());
      r = $urandom_range(0, 9);
      if (r == 0) push_byte(CH_PLUS);
      else if (r == 1) push_byte(CH_MINUS);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // no digits at all
      end else if (r < 15) push_number(9999);
      else if (r < 20) push_number(10000);
      else if (r < 25) push_number(0);
      else if (r < 30) push_number($urandom_range(10000, 999999));
      else push_number($urandom_range(0, 9999));
      if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) push_crlf();
    end else if (kind < 63) begin
      bad = $urandom_range(0, PREFIX_LEN - 1);
      for (int i = 0; i < PREFIX_LEN; i++)
        push_byte((i == bad) ? 8'($urandom_range(0, 255)) : PREFIX_TEXT[71 - 8*i -: 8]);
      push_number($urandom_range(0, 9999));
      push_crlf();
    end else if (kind < 71) begin
      push_prefix($urandom_range(0, PREFIX_LEN));
      push_crlf();
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) push_crlf();
    end else if (kind < 87) begin
      // Overlong line that fills the buffer before its end.
      push_prefix(PREFIX_LEN);
      n = $urandom_range(54, 70);
      for (int i = 0; i < n; i++)
        push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'(CH_ZERO + $urandom_range(0, 9)));
      push_crlf();
    end else if (kind < 94) begin
      push_prefix(PREFIX_LEN);
      push_byte(CH_MINUS);
      r = $urandom_range(0, 2);
      if (r == 0) push_byte(CH_ZERO);
      else if (r == 1) begin
        push_byte(CH_ZERO);
        push_byte(CH_ZERO);
      end else push_number($urandom_range(1, 99));
      push_crlf();
    end else begin
      r = $urandom_range(0, 2);
      if (r == 0) push_crlf();
      else if (r == 1) begin
        push_byte(CH_CR);
        push_crlf();
      end else push_byte(CH_LF);
    end
  endtask

  // Idle once every queued byte has come back as a checked result.
  task automatic wait_idle();
    while (results_seen < bytes_queued) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    p_timeout  = v;
    ph_timeout = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] settings[5];
    int unsigned start;
    p_timeout   = TIMEOUT_RST;
    ph_timeout  = TIMEOUT_RST;
    p_last_ms   = '0;
    p_prev_byte = '0;
    p_distance  = '0;
    clear_line_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a full-range value across the tick wrap, a CR and LF split by a gap just
    // past the timeout, extreme bytes at a gap of exactly the timeout, and a short line.
    cur_ms = 32'hFFFF_FFF8;
    push_at(PREFIX_TEXT[71 -: 8], cur_ms);
    for (int i = 1; i < PREFIX_LEN; i++) push_at(PREFIX_TEXT[71 - 8*i -: 8], cur_ms + 1);
    for (int i = 0; i < 4; i++) push_at(8'(CH_NINE), cur_ms + 1);
    push_at(CH_CR, cur_ms + 1);
    push_at(CH_LF, cur_ms + 1);
    push_at(CH_CR, 32'hFFFF_FFFF);
    push_at(CH_LF, 32'hFFFF_FFFF + TIMEOUT_RST + 1);
    push_at(8'hFF, cur_ms + 1);
    push_at(8'h00, cur_ms + TIMEOUT_RST);
    push_at(CH_CR, cur_ms);
    push_at(CH_LF, cur_ms);
    wait_idle();

    settings[0] = 32'd0;
    settings[1] = 32'hFFFF_FFFF;
    settings[2] = $urandom();
    settings[3] = $urandom_range(1, 20);
    settings[4] = TIMEOUT_RST;
    foreach (settings[k]) begin
      write_timeout(settings[k]);
      start = bytes_queued;
      while (bytes_queued - start < PHASE_ITEMS) gen_line();
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (result_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, result_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
